FILE: rtl/ndrm_pkg.sv
// Package for the NIC descriptor ring manager: sizes, register indexes,
// status bits, item kinds and the request/response transfer structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ndrm_pkg;

  localparam int TX_SLOTS        = 8;
  localparam int RX_SLOTS        = 8;
  localparam int RX_BUFFER_BYTES = 2048;

  localparam int TX_PTR_W = $clog2(TX_SLOTS);
  localparam int RX_PTR_W = $clog2(RX_SLOTS);

  localparam int SLOT_W  = 3;
  localparam int LEN_W   = 12;
  localparam int CNT_W   = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [LEN_W-1:0] MIN_HEADER_LEN  = LEN_W'(14);
  localparam logic [LEN_W-1:0] MAX_TX_RESET    = LEN_W'(1536);
  localparam logic [LEN_W-1:0] MIN_WIRE_RESET  = LEN_W'(60);
  localparam logic [LEN_W-1:0] RX_BUF_LEN      = LEN_W'(RX_BUFFER_BYTES);

  // descriptor status byte
  localparam logic [7:0] ST_DONE = 8'h01;
  localparam logic [7:0] ST_EOP  = 8'h02;
  localparam int ST_DONE_BIT = 0;
  localparam int ST_EOP_BIT  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_ENABLE       = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TX_LENGTH   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_WIRE_LENGTH = CFG_IDX_W'(3);

  typedef enum logic [1:0] {
    KIND_SEND    = 2'd0,
    KIND_TX_DONE = 2'd1,
    KIND_ARRIVAL = 2'd2,
    KIND_POLL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  frame_length;
    logic              have_frame;
    logic [15:0]       poll_buf_bytes;
    logic              arrival_eop;
    logic [7:0]        arrival_errors;
    logic [15:0]       arrival_ethertype;
  } req_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  padded_len;
    logic [15:0]       reported_len;
    logic [7:0]        last_status;
    logic [7:0]        last_errors;
    logic [15:0]       last_type;
    logic [CNT_W-1:0]  attempts_count;
    logic [CNT_W-1:0]  sent_count;
    logic [CNT_W-1:0]  tx_error_count;
    logic [CNT_W-1:0]  rx_packet_count;
    logic [CNT_W-1:0]  rx_error_count;
  } rsp_t;

  // one receive descriptor as held in the slot memory
  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        errors;
    logic [LEN_W-1:0]  length;
    logic [15:0]       ethertype;
  } rx_entry_t;

endpackage

`default_nettype wire

FILE: rtl/nic_descriptor_ring_manager.sv
// NIC descriptor ring manager: transmit ring done bits, receive slot memory,
// statistics counters. Uses ndrm_pkg.
// Timing: the request transfer edge registers the slot memory read; then in
//   S_EXEC the read-modify-write is done and the response is loaded, once the
//   response register is free. A new request is taken only after the item
//   completes, since the request channel stalls while an item executes.
// Reset (rst, synchronous): pointers, counters and last fields zero, all tx
//   done bits set, all rx slots read as empty at once via per-slot valid bits.
`timescale 1ns / 1ps
`default_nettype none

module nic_descriptor_ring_manager
  import ndrm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // request channel
  input  wire logic                  req_valid,
  output logic                       req_stall,
  input  wire req_t                  req,
  // response channel
  output logic                       rsp_valid,
  input  wire logic                  rsp_stall,
  output rsp_t                       rsp,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;

  // configuration registers
  logic             tx_enable;
  logic             rx_enable;
  logic [LEN_W-1:0] max_tx_length;
  logic [LEN_W-1:0] min_wire_length;

  // transmit ring: done bits in flops, pointers
  logic [TX_SLOTS-1:0] tx_done, tx_done_next;
  logic [TX_PTR_W-1:0] tx_tail, tx_tail_next;
  logic [TX_PTR_W-1:0] tx_head, tx_head_next;

  // receive ring: slot memory plus per-slot valid bits (reset clears them,
  // an invalid slot reads as all zero)
  rx_entry_t           rx_mem [RX_SLOTS];
  logic [RX_SLOTS-1:0] rx_valid;
  logic [RX_PTR_W-1:0] rx_read_ptr, rx_read_ptr_next;
  logic [RX_PTR_W-1:0] rx_fill_ptr, rx_fill_ptr_next;
  logic [RX_PTR_W-1:0] rd_addr, rd_addr_q;
  rx_entry_t           rd_q;
  logic                rd_vld_q;
  rx_entry_t           entry;
  logic                wr_en;
  rx_entry_t           wr_data;

  // counters and last-looked-at fields
  logic [CNT_W-1:0] attempts_count, attempts_count_next;
  logic [CNT_W-1:0] sent_count, sent_count_next;
  logic [CNT_W-1:0] tx_error_count, tx_error_count_next;
  logic [CNT_W-1:0] rx_packet_count, rx_packet_count_next;
  logic [CNT_W-1:0] rx_error_count, rx_error_count_next;
  logic [7:0]       last_status, last_status_next;
  logic [7:0]       last_errors, last_errors_next;
  logic [15:0]      last_type, last_type_next;

  req_t  item;
  logic  accept;
  logic  fire;
  rsp_t  result;

  logic [RX_PTR_W-1:0] rx_slot;
  logic [15:0]         len16;

  // One request at a time: the request channel is open only in S_IDLE.
  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  // EXEC completes once the response register is free or being emptied.
  assign fire      = (state == S_EXEC) && !(rsp_valid && rsp_stall);

  assign cfg_ready = 1'b1;

  // Arrivals look at the fill slot, everything else at the read slot.
  assign rd_addr = (req.kind == KIND_ARRIVAL) ? rx_fill_ptr : rx_read_ptr;
  assign entry   = rd_vld_q ? rd_q : '0;
  assign len16   = 16'(entry.length);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (accept) state <= S_EXEC;
        S_EXEC: if (fire) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_enable       <= 1'b0;
      rx_enable       <= 1'b0;
      max_tx_length   <= MAX_TX_RESET;
      min_wire_length <= MIN_WIRE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TX_ENABLE:       tx_enable       <= cfg_data[0];
        REG_RX_ENABLE:       rx_enable       <= cfg_data[0];
        REG_MAX_TX_LENGTH:   max_tx_length   <= cfg_data[LEN_W-1:0];
        REG_MIN_WIRE_LENGTH: min_wire_length <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture and slot memory read (registered read data)
  always_ff @(posedge clk) begin
    if (accept) begin
      item      <= req;
      rd_addr_q <= rd_addr;
      rd_q      <= rx_mem[rd_addr];
      rd_vld_q  <= rx_valid[rd_addr];
    end
  end

  // slot memory write-back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rx_mem[rd_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_valid <= '0;
    end else if (wr_en) begin
      rx_valid[rd_addr_q] <= 1'b1;
    end
  end

  // read-modify-write of one item
  always_comb begin
    tx_done_next         = tx_done;
    tx_tail_next         = tx_tail;
    tx_head_next         = tx_head;
    rx_read_ptr_next     = rx_read_ptr;
    rx_fill_ptr_next     = rx_fill_ptr;
    attempts_count_next  = attempts_count;
    sent_count_next      = sent_count;
    tx_error_count_next  = tx_error_count;
    rx_packet_count_next = rx_packet_count;
    rx_error_count_next  = rx_error_count;
    last_status_next     = last_status;
    last_errors_next     = last_errors;
    last_type_next       = last_type;
    wr_en                = 1'b0;
    wr_data              = '0;
    rx_slot              = rd_addr_q;
    result               = '0;

    case (item.kind)
      KIND_SEND: begin
        result.slot      = SLOT_W'(tx_tail);
        last_status_next = 8'h00;
        if (!tx_enable || !item.have_frame || (item.frame_length > max_tx_length)
            || !tx_done[tx_tail]) begin
          tx_error_count_next = tx_error_count + CNT_W'(1);
        end else begin
          result.ok           = 1'b1;
          result.padded_len   = (item.frame_length < min_wire_length) ?
                                min_wire_length : item.frame_length;
          tx_done_next[tx_tail] = 1'b0;
          attempts_count_next = attempts_count + CNT_W'(1);
          tx_tail_next = (tx_tail == TX_PTR_W'(TX_SLOTS - 1)) ? '0 :
                         tx_tail + TX_PTR_W'(1);
        end
      end

      KIND_TX_DONE: begin
        result.slot = SLOT_W'(tx_head);
        if (!tx_done[tx_head]) begin
          result.ok             = 1'b1;
          tx_done_next[tx_head] = 1'b1;
          last_status_next      = ST_DONE;
          sent_count_next       = sent_count + CNT_W'(1);
          tx_head_next = (tx_head == TX_PTR_W'(TX_SLOTS - 1)) ? '0 :
                         tx_head + TX_PTR_W'(1);
        end
      end

      KIND_ARRIVAL: begin
        result.slot = SLOT_W'(rx_slot);
        if (rx_enable && !entry.status[ST_DONE_BIT]) begin
          result.ok         = 1'b1;
          wr_en             = 1'b1;
          wr_data.status    = {item.arrival_eop, 1'b1};
          wr_data.errors    = item.arrival_errors;
          wr_data.length    = (item.frame_length > RX_BUF_LEN) ? RX_BUF_LEN :
                              item.frame_length;
          wr_data.ethertype = item.arrival_ethertype;
          rx_fill_ptr_next = (rx_fill_ptr == RX_PTR_W'(RX_SLOTS - 1)) ? '0 :
                             rx_fill_ptr + RX_PTR_W'(1);
        end
      end

      default: begin // KIND_POLL
        result.slot = SLOT_W'(rx_slot);
        if (!rx_enable) begin
          rx_error_count_next = rx_error_count + CNT_W'(1);
          last_status_next    = 8'h00;
          last_errors_next    = 8'h00;
        end else if (!entry.status[ST_DONE_BIT]) begin
          last_status_next = {6'b0, entry.status};
          last_errors_next = entry.errors;
        end else begin
          result.ok        = 1'b1;
          last_status_next = {6'b0, entry.status};
          last_errors_next = entry.errors;
          last_type_next   = 16'h0000;
          // short frame: no ethertype, nothing copied
          if (entry.length >= MIN_HEADER_LEN) begin
            last_type_next      = entry.ethertype;
            result.reported_len = ((item.poll_buf_bytes != 16'h0000) &&
                                   (len16 > item.poll_buf_bytes)) ?
                                  item.poll_buf_bytes : len16;
          end
          if ((entry.errors != 8'h00) || !entry.status[ST_EOP_BIT]) begin
            rx_error_count_next = rx_error_count + CNT_W'(1);
          end else begin
            rx_packet_count_next = rx_packet_count + CNT_W'(1);
          end
          wr_en   = 1'b1;
          wr_data = '0;
          rx_read_ptr_next = (rx_read_ptr == RX_PTR_W'(RX_SLOTS - 1)) ? '0 :
                             rx_read_ptr + RX_PTR_W'(1);
        end
      end
    endcase

    if (!fire) begin
      wr_en = 1'b0;
    end

    result.last_status     = last_status_next;
    result.last_errors     = last_errors_next;
    result.last_type       = last_type_next;
    result.attempts_count  = attempts_count_next;
    result.sent_count      = sent_count_next;
    result.tx_error_count  = tx_error_count_next;
    result.rx_packet_count = rx_packet_count_next;
    result.rx_error_count  = rx_error_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_done         <= '1;
      tx_tail         <= '0;
      tx_head         <= '0;
      rx_read_ptr     <= '0;
      rx_fill_ptr     <= '0;
      attempts_count  <= '0;
      sent_count      <= '0;
      tx_error_count  <= '0;
      rx_packet_count <= '0;
      rx_error_count  <= '0;
      last_status     <= '0;
      last_errors     <= '0;
      last_type       <= '0;
    end else if (fire) begin
      tx_done         <= tx_done_next;
      tx_tail         <= tx_tail_next;
      tx_head         <= tx_head_next;
      rx_read_ptr     <= rx_read_ptr_next;
      rx_fill_ptr     <= rx_fill_ptr_next;
      attempts_count  <= attempts_count_next;
      sent_count      <= sent_count_next;
      tx_error_count  <= tx_error_count_next;
      rx_packet_count <= rx_packet_count_next;
      rx_error_count  <= rx_error_count_next;
      last_status     <= last_status_next;
      last_errors     <= last_errors_next;
      last_type       <= last_type_next;
    end
  end

  // response register: holds a finished transfer until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

`ifndef SYNTHESIS
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_EXEC))
    else $error("accepted request did not enter execute");

  a_fire_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> (rsp_valid && (state == S_IDLE)))
    else $error("completed request did not load response");

  a_ring_full_empty: assert property (@(posedge clk) disable iff (rst)
    (tx_tail == tx_head) |-> ((tx_done == '1) || (tx_done == '0)))
    else $error("tx ring pointers equal with mixed done bits");

  a_outstanding: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(~tx_done)) == (attempts_count - sent_count))
    else $error("outstanding tx slots disagree with counters");
`endif

endmodule

`default_nettype wire
